@@ src/erm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erm_pkg: shared types and constants for the Euler rotation matrix core
// Word formats, CORDIC arctangent table and the fixed-point helpers.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int IN_W           = 16;
  localparam int OUT_W          = 16;
  localparam int CORDIC_STEPS   = 24;
  localparam int STEP_W         = $clog2(CORDIC_STEPS);
  localparam int XW             = 33;   // CORDIC x/y width
  localparam int ZW             = 33;   // residual angle width
  localparam int TW             = 32;   // Q30 trig/product width
  localparam int SW             = 40;   // rounding headroom

  localparam logic signed [XW-1:0] CORDIC_X0 = XW'(32'h26DD3B6A);

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam int RND_SH = 30 - COEF_FRAC_BITS;
  localparam logic signed [SW-1:0] RND_HALF =
    (RND_SH > 0) ? (SW'(1) << ((RND_SH > 0) ? RND_SH - 1 : 0)) : '0;
  localparam logic signed [SW-1:0] COEF_ONE = SW'(1) << COEF_FRAC_BITS;

  // One axis in flight through the CORDIC chain
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
  } rot_t;

  // Three axes: index 0 = x, 1 = y, 2 = z
  typedef struct packed {
    rot_t [2:0] ax;
  } cell_word_t;

  // Q30 product, rounded half up, floor shift
  function automatic logic signed [TW-1:0] mul_q30(input logic signed [TW-1:0] a,
                                                   input logic signed [TW-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
    return p[61:30];
  endfunction

  // Round Q30 to the coefficient format, saturate to +-1, keep low bits
  function automatic logic [OUT_W-1:0] to_out(input logic signed [TW+1:0] v);
    logic signed [SW-1:0] w;
    w = SW'(v) + RND_HALF;
    w = w >>> RND_SH;
    if (w > COEF_ONE) w = COEF_ONE;
    if (w < -COEF_ONE) w = -COEF_ONE;
    return w[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ src/erm_cordic_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erm_cordic_cell: one rotation-mode CORDIC step for three axes
// Registered micro-rotation with a local valid and a ready chain.
// ----------------------------------------------------------------------------
module erm_cordic_cell
  import erm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [STEP_W-1:0] step,
  input  wire logic              up_valid,
  input  wire cell_word_t        up_word,
  output logic                   up_ready,
  output logic                   dn_valid,
  output cell_word_t             dn_word,
  input  wire logic              dn_ready
);

  cell_word_t word_next;
  logic signed [ZW-1:0] atan_v;

  assign atan_v   = ZW'(ATAN_TURNS[step]);
  assign up_ready = !dn_valid || dn_ready;

  // micro-rotation, direction from the sign of the residual
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      word_next.ax[a].quad = up_word.ax[a].quad;
      if (!up_word.ax[a].z[ZW-1]) begin
        word_next.ax[a].x = up_word.ax[a].x - (up_word.ax[a].y >>> step);
        word_next.ax[a].y = up_word.ax[a].y + (up_word.ax[a].x >>> step);
        word_next.ax[a].z = up_word.ax[a].z - atan_v;
      end else begin
        word_next.ax[a].x = up_word.ax[a].x + (up_word.ax[a].y >>> step);
        word_next.ax[a].y = up_word.ax[a].y - (up_word.ax[a].x >>> step);
        word_next.ax[a].z = up_word.ax[a].z + atan_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word <= word_next;
    end
  end

endmodule
`default_nettype wire

@@ src/erm_matrix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erm_matrix: quadrant fold and product network
// Four registered stages: fold, pair products, triple products, round/sum.
// ----------------------------------------------------------------------------
module erm_matrix
  import erm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       up_valid,
  input  wire cell_word_t up_word,
  output logic            up_ready,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [OUT_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  logic [3:0] v;
  logic [3:0] rdy;

  assign rdy[3]    = !v[3] || !out_stall;
  assign rdy[2]    = !v[2] || rdy[3];
  assign rdy[1]    = !v[1] || rdy[2];
  assign rdy[0]    = !v[0] || rdy[1];
  assign up_ready  = rdy[0];
  assign out_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= up_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
    end
  end

  // stage 1: quadrant fold to sine/cosine
  logic signed [TW-1:0] s_r [3], c_r [3];
  logic signed [XW-1:0] s_f [3], c_f [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      unique case (up_word.ax[a].quad)
        2'd0: begin c_f[a] = up_word.ax[a].x;  s_f[a] = up_word.ax[a].y;  end
        2'd1: begin c_f[a] = -up_word.ax[a].y; s_f[a] = up_word.ax[a].x;  end
        2'd2: begin c_f[a] = -up_word.ax[a].x; s_f[a] = -up_word.ax[a].y; end
        default: begin c_f[a] = up_word.ax[a].y; s_f[a] = -up_word.ax[a].x; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && up_valid) begin
      for (int a = 0; a < 3; a++) begin
        s_r[a] <= s_f[a][TW-1:0];
        c_r[a] <= c_f[a][TW-1:0];
      end
    end
  end

  // stage 2: pair products
  logic signed [TW-1:0] czsy, szsy, czcy, szcy, szcx, szsx, czcx, czsx, cysx, cycx;
  logic signed [TW-1:0] sx2, cx2, sy2;

  always_ff @(posedge clk) begin
    if (rdy[1] && v[0]) begin
      czsy <= mul_q30(c_r[2], s_r[1]);
      szsy <= mul_q30(s_r[2], s_r[1]);
      czcy <= mul_q30(c_r[2], c_r[1]);
      szcy <= mul_q30(s_r[2], c_r[1]);
      szcx <= mul_q30(s_r[2], c_r[0]);
      szsx <= mul_q30(s_r[2], s_r[0]);
      czcx <= mul_q30(c_r[2], c_r[0]);
      czsx <= mul_q30(c_r[2], s_r[0]);
      cysx <= mul_q30(c_r[1], s_r[0]);
      cycx <= mul_q30(c_r[1], c_r[0]);
      sx2  <= s_r[0];
      cx2  <= c_r[0];
      sy2  <= s_r[1];
    end
  end

  // stage 3: triple products, pass the rest along
  logic signed [TW-1:0] t01, t02, t11, t12;
  logic signed [TW-1:0] szcx3, szsx3, czcx3, czsx3, czcy3, szcy3, cysx3, cycx3, sy3;

  always_ff @(posedge clk) begin
    if (rdy[2] && v[1]) begin
      t01   <= mul_q30(czsy, sx2);
      t02   <= mul_q30(czsy, cx2);
      t11   <= mul_q30(szsy, sx2);
      t12   <= mul_q30(szsy, cx2);
      szcx3 <= szcx;
      szsx3 <= szsx;
      czcx3 <= czcx;
      czsx3 <= czsx;
      czcy3 <= czcy;
      szcy3 <= szcy;
      cysx3 <= cysx;
      cycx3 <= cycx;
      sy3   <= sy2;
    end
  end

  // stage 4: sums, rounding and saturation into the output word
  always_ff @(posedge clk) begin
    if (rdy[3] && v[2]) begin
      m00 <= to_out((TW+2)'(czcy3));
      m01 <= to_out((TW+2)'(t01) - (TW+2)'(szcx3));
      m02 <= to_out((TW+2)'(t02) + (TW+2)'(szsx3));
      m10 <= to_out((TW+2)'(szcy3));
      m11 <= to_out((TW+2)'(t11) + (TW+2)'(czcx3));
      m12 <= to_out((TW+2)'(t12) - (TW+2)'(czsx3));
      m20 <= to_out(-((TW+2)'(sy3)));
      m21 <= to_out((TW+2)'(cysx3));
      m22 <= to_out((TW+2)'(cycx3));
    end
  end

  // a stage that is empty always takes a word
  a_empty_ready: assert property (@(posedge clk) disable iff (rst) !v[0] |-> up_ready)
    else $error("erm_matrix: empty first stage not ready");

  // a stalled stage keeps its word
  a_hold: assert property (@(posedge clk) disable iff (rst) v[2] && !rdy[2] |=> v[2])
    else $error("erm_matrix: stalled stage lost its word");

  // saturated coefficients stay within +-1 when they fit the field
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (COEF_FRAC_BITS > OUT_W - 2) ||
      (($signed(m00) <= COEF_ONE) && ($signed(m00) >= -COEF_ONE) &&
       ($signed(m11) <= COEF_ONE) && ($signed(m11) >= -COEF_ONE)))
    else $error("erm_matrix: coefficient beyond unity");

endmodule
`default_nettype wire

@@ src/euler_rotation_matrix_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An accepted word passes through 24 CORDIC cells and 4 product stages to its result.
// Throughput: one word per cycle while the output is not stalled; every cell and product stage is a register stage.
// A stalled output fills the chain before in_stall rises.
// Reset (rst, synchronous) clears every stage valid flag; data registers are not reset.
// ----------------------------------------------------------------------------
// euler_rotation_matrix_core: Z*Y*X rotation matrix from three binary angles
// Chain of CORDIC cells for sine/cosine, then a pipelined product network.
// ----------------------------------------------------------------------------
module euler_rotation_matrix_core
  import erm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [IN_W-1:0]   angle_x,
  input  wire logic [IN_W-1:0]   angle_y,
  input  wire logic [IN_W-1:0]   angle_z,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [OUT_W-1:0]       m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  cell_word_t dat [CORDIC_STEPS+1];
  logic       vld [CORDIC_STEPS+1];
  logic       rdy [CORDIC_STEPS+1];

  // widen angles to turn units, split quadrant and residual
  logic [IN_W-1:0] ang [3];
  logic [31:0]     turn [3];
  cell_word_t      head;

  assign ang[0] = angle_x;
  assign ang[1] = angle_y;
  assign ang[2] = angle_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      turn[a] = {{(32-IN_W){1'b0}}, ang[a]} << (32 - ANGLE_BITS);
      head.ax[a].quad = turn[a][31:30];
      head.ax[a].z    = ZW'(turn[a][29:0]);
      head.ax[a].x    = CORDIC_X0;
      head.ax[a].y    = '0;
    end
  end

  assign dat[0]   = head;
  assign vld[0]   = in_valid;
  assign in_stall = !rdy[0];

  // CORDIC chain
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    erm_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step     (STEP_W'(k)),
      .up_valid (vld[k]),
      .up_word  (dat[k]),
      .up_ready (rdy[k]),
      .dn_valid (vld[k+1]),
      .dn_word  (dat[k+1]),
      .dn_ready (rdy[k+1])
    );
  end

  // products and output word
  erm_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (vld[CORDIC_STEPS]),
    .up_word   (dat[CORDIC_STEPS]),
    .up_ready  (rdy[CORDIC_STEPS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .m00 (m00), .m01 (m01), .m02 (m02),
    .m10 (m10), .m11 (m11), .m12 (m12),
    .m20 (m20), .m21 (m21), .m22 (m22)
  );

endmodule
`default_nettype wire

@@ sim/tb_euler_rotation_matrix_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_rotation_matrix_core: self-checking bench for the rotation core
// Drives random and corner-case angle triples through the valid/stall input,
// predicts each Z*Y*X matrix with a bit-exact CORDIC model, and compares every
// output word against the oldest prediction in a scoreboard.
// ----------------------------------------------------------------------------
module tb_euler_rotation_matrix_core;
  import erm_pkg::*;

  // Expected matrix, row major
  typedef struct {
    logic [15:0] m [9];
  } matrix_t;

  // Bit-exact sine/cosine and matrix prediction
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic void trig(logic [15:0] ang, output longint s, output longint c);
    logic [31:0] u;
    longint x, y, z, dx, dy;
    u = {ang[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    z = longint'(u[29:0]);
    x = 64'h26DD3B6A;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end
    end
    case (u[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [15:0] round_sat(longint q);
    longint v, one;
    int sh;
    sh = 30 - COEF_FRAC_BITS;
    one = 64'sd1 <<< COEF_FRAC_BITS;
    v = q;
    if (sh > 0) v = floor_shr(q + (64'sd1 <<< (sh - 1)), sh);
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[15:0];
  endfunction

  function automatic matrix_t rotation_of(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    matrix_t r;
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    trig(ax, sx, cx);
    trig(ay, sy, cy);
    trig(az, sz, cz);
    czsy = q30_mul(cz, sy);
    szsy = q30_mul(sz, sy);
    r.m[0] = round_sat(q30_mul(cz, cy));
    r.m[1] = round_sat(q30_mul(czsy, sx) - q30_mul(sz, cx));
    r.m[2] = round_sat(q30_mul(czsy, cx) + q30_mul(sz, sx));
    r.m[3] = round_sat(q30_mul(sz, cy));
    r.m[4] = round_sat(q30_mul(szsy, sx) + q30_mul(cz, cx));
    r.m[5] = round_sat(q30_mul(szsy, cx) - q30_mul(cz, sx));
    r.m[6] = round_sat(-sy);
    r.m[7] = round_sat(q30_mul(cy, sx));
    r.m[8] = round_sat(q30_mul(cy, cx));
    return r;
  endfunction

  // Scoreboard of pending matrices
  class matrix_board;
    matrix_t pending[$];
    int errors = 0;

    function void note_angles(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
      pending.push_back(rotation_of(ax, ay, az));
    endfunction

    function void check_matrix(matrix_t got);
      matrix_t want;
      string names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
      if (pending.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got.m[i] !== want.m[i]) begin
          $error("%s: expected %h, got %h", names[i], want.m[i], got.m[i]);
          errors++;
        end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
  wire in_stall, out_valid;
  wire [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  matrix_board board = new();
  bit stim_done = 1'b0;
  bit long_hold = 1'b0;

  always #5 clk = ~clk;

  euler_rotation_matrix_core u_top (
    .clk, .rst, .in_valid, .in_stall, .angle_x, .angle_y, .angle_z,
    .out_valid, .out_stall, .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22
  );

  // Note accepted words and check results at each edge
  always @(posedge clk) begin
    matrix_t got;
    if (!rst) begin
      if (in_valid && !in_stall) board.note_angles(angle_x, angle_y, angle_z);
      if (out_valid && !out_stall) begin
        got.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
        board.check_matrix(got);
      end
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_word(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    in_valid <= 1'b1;
    angle_x <= ax;
    angle_y <= ay;
    angle_z <= az;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    logic [15:0] corners [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                  16'h7FFF, 16'h0001, 16'hFFFF, 16'h2000};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  // Receiver stall pattern, with one long hold-off
  initial begin
    int run;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
      run = $urandom_range(0, 3);
      case (run)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'b1;
        default: out_stall <= ($urandom_range(0, 2) == 0);
      endcase
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    logic [15:0] dir [12] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF,
                               16'h8001, 16'h0001, 16'hFFFF, 16'h2000, 16'h6000,
                               16'hA000, 16'hE000};
    int burst;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // corners: mixed triples, then all three axes equal
    for (int i = 0; i < 12; i++) send_word(dir[i], dir[(i + 4) % 12], dir[(i + 7) % 12]);
    for (int i = 0; i < 8; i++) send_word(dir[i], dir[i], dir[i]);
    send_word(16'h5555, 16'hAAAA, 16'h0000);
    send_word(16'hAAAA, 16'h5555, 16'hFFFF);
    idle_cycles(1);
    // sender pause until drained
    while (board.pending.size() != 0) @(posedge clk);
    // long receiver hold-off while offering words
    long_hold = 1'b1;
    for (int i = 0; i < 100; i++) send_word(pick_angle(), pick_angle(), pick_angle());
    // random bursts
    for (int n = 0; n < 800; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        send_word(pick_angle(), pick_angle(), pick_angle());
        n++;
      end
      if ($urandom_range(0, 1)) idle_cycles($urandom_range(1, 15));
    end
    idle_cycles(1);
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
